// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the sentence splitter RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/splt_pkg.sv -----
// Shared types and constants of the punctuation sentence splitter.
// Used by splt_front, splt_back and the top level; depends on nothing.
`default_nettype none

package splt_pkg;

    localparam logic KIND_TEXT  = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_PERIOD = 8'h2E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // Table entries per OR group in the match reduction.
    localparam int GROUP_SIZE = 16;

    // Field positions inside the input tdata word.
    localparam int TEXT_LSB   = 0;
    localparam int INDEX_LSB  = 8;
    localparam int FIRST_LSB  = 15;
    localparam int SECOND_LSB = 23;
    localparam int TWO_BIT    = 31;
    localparam int IN_DATA_W  = 32;

    typedef struct packed {
        logic       two_byte;
        logic [7:0] second;
        logic [7:0] first;
    } entry_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       single_hit;
        logic       pair_hit;
    } text_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       seg_end;
        logic       line_end;
    } out_item_t;

    typedef enum logic [1:0] {
        HELD_NONE,
        HELD_LEAD,
        HELD_PUNCT
    } held_state_t;

endpackage

`default_nettype wire

// ----- rtl/splt_fifo.sv -----
// Small synchronous FIFO that decouples the classifier from the sequencer.
// Generic width; DEPTH must be a power of two. No package dependency.
`default_nettype none
`include "assert_macros.svh"

module splt_fifo #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 4,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty,
    output logic      [CNT_W-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

    `ASSERT_IMPLY(a_no_overflow, push && !pop, count_reg < CNT_W'(DEPTH), "FIFO push while full")
    `ASSERT_IMPLY(a_no_underflow, pop, !empty, "FIFO pop while empty")
    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DEPTH), "FIFO count out of range")

endmodule

`default_nettype wire

// ----- rtl/splt_front.sv -----
// Front end: accepts stream transfers, holds the punctuation table and the entry
// count, and matches each text byte against all active entries. Depends on splt_pkg.
`default_nettype none

module splt_front
    import splt_pkg::*;
#(
    parameter int TABLE_DEPTH = 128,
    parameter int QUEUE_DEPTH = 4,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic [0:0]           s_axis_tuser,
    input  wire logic                 s_axis_tlast,
    input  wire logic                 cfg_wr_en,
    input  wire logic [7:0]           cfg_wr_data,
    input  wire logic [CNT_W-1:0]     q_count,
    output logic                      q_push,
    output text_item_t                q_push_data
);

    localparam int NUM_GROUPS = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_DEPTH  = NUM_GROUPS * GROUP_SIZE;

    logic                  text_acc;
    logic                  entry_acc;
    logic [7:0]            in_byte;
    logic [8:0]            wr_index;
    entry_t                wr_entry;
    logic [7:0]            count_reg;
    logic [7:0]            prev_byte_reg;
    entry_t                entry_reg [TABLE_DEPTH];
    logic [PAD_DEPTH-1:0]  hit_single;
    logic [PAD_DEPTH-1:0]  hit_pair;
    logic [NUM_GROUPS-1:0] grp_single;
    logic [NUM_GROUPS-1:0] grp_pair;
    logic                  s1_valid_reg;
    logic [7:0]            s1_data_reg;
    logic                  s1_last_reg;
    logic [NUM_GROUPS-1:0] s1_single_reg;
    logic [NUM_GROUPS-1:0] s1_pair_reg;

    // Credit check: room for what sits in the queue and in the match stage.
    assign s_axis_tready = ({1'b0, q_count} + (CNT_W + 1)'(s1_valid_reg))
                           < (CNT_W + 1)'(QUEUE_DEPTH);

    assign text_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == KIND_TEXT);
    assign entry_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == KIND_ENTRY);
    assign in_byte   = s_axis_tdata[TEXT_LSB +: 8];
    assign wr_index  = {2'b00, s_axis_tdata[INDEX_LSB +: 7]};

    assign wr_entry.first    = s_axis_tdata[FIRST_LSB +: 8];
    assign wr_entry.second   = s_axis_tdata[SECOND_LSB +: 8];
    assign wr_entry.two_byte = s_axis_tdata[TWO_BIT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_acc)
        begin
            prev_byte_reg <= in_byte;
        end
    end

    for (genvar k = 0; k < PAD_DEPTH; k++)
    begin : g_entry
        if (k < TABLE_DEPTH)
        begin : g_real
            logic active;

            always_ff @(posedge clk)
            begin
                if (entry_acc && (wr_index == 9'(k)))
                begin
                    entry_reg[k] <= wr_entry;
                end
            end

            assign active        = 9'(k) < {1'b0, count_reg};
            assign hit_single[k] = active && !entry_reg[k].two_byte
                                   && (entry_reg[k].first == in_byte);
            assign hit_pair[k]   = active && entry_reg[k].two_byte
                                   && (entry_reg[k].first == prev_byte_reg)
                                   && (entry_reg[k].second == in_byte);
        end
        else
        begin : g_pad
            assign hit_single[k] = 1'b0;
            assign hit_pair[k]   = 1'b0;
        end
    end

    for (genvar g = 0; g < NUM_GROUPS; g++)
    begin : g_group
        assign grp_single[g] = |hit_single[g * GROUP_SIZE +: GROUP_SIZE];
        assign grp_pair[g]   = |hit_pair[g * GROUP_SIZE +: GROUP_SIZE];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= text_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_acc)
        begin
            s1_data_reg   <= in_byte;
            s1_last_reg   <= s_axis_tlast;
            s1_single_reg <= grp_single;
            s1_pair_reg   <= grp_pair;
        end
    end

    assign q_push                 = s1_valid_reg;
    assign q_push_data.data       = s1_data_reg;
    assign q_push_data.last       = s1_last_reg;
    assign q_push_data.single_hit = |s1_single_reg;
    assign q_push_data.pair_hit   = |s1_pair_reg;

endmodule

`default_nettype wire

// ----- rtl/splt_back.sv -----
// Back end: holds back lead bytes and matched commas or periods, decides the
// segment ends and buffers results for the output stream. Depends on splt_pkg.
`default_nettype none
`include "assert_macros.svh"

module splt_back
    import splt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_empty,
    output logic             q_pop,
    input  text_item_t       q_data,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,
    output logic [0:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    held_state_t          held_reg;
    held_state_t          held_next;
    logic [7:0]           held_byte_reg;
    logic [7:0]           held_byte_next;
    out_item_t            out_buf_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] out_wr_ptr_reg;
    logic [OUT_PTR_W-1:0] out_rd_ptr_reg;
    logic [OUT_CNT_W-1:0] out_count_reg;
    logic [OUT_CNT_W-1:0] out_count_next;
    logic                 drain;
    logic                 is_digit;
    logic                 is_punct;
    logic                 is_lead;
    logic                 own_emit;
    out_item_t            own_res;
    out_item_t            res0;
    out_item_t            res1;
    logic [1:0]           res_cnt;

    assign q_pop = !q_empty && (out_count_reg <= OUT_CNT_W'(OUT_DEPTH - 2));
    assign drain = m_axis_tvalid && m_axis_tready;

    assign is_digit = (q_data.data >= CHAR_ZERO) && (q_data.data <= CHAR_NINE);
    assign is_punct = (q_data.data == CHAR_COMMA) || (q_data.data == CHAR_PERIOD);
    assign is_lead  = q_data.data[7];
    assign own_emit = q_data.last || (!is_lead && !(q_data.single_hit && is_punct));

    assign own_res.data     = q_data.data;
    assign own_res.seg_end  = q_data.last || q_data.single_hit;
    assign own_res.line_end = q_data.last;

    // Next state of the held character.
    always_comb
    begin
        held_next      = held_reg;
        held_byte_next = held_byte_reg;
        if (q_pop)
        begin
            unique case (held_reg) inside
                HELD_LEAD:
                begin
                    held_next = HELD_NONE;
                end
                HELD_NONE, HELD_PUNCT:
                begin
                    held_byte_next = q_data.data;
                    if (!q_data.last && is_lead)
                    begin
                        held_next = HELD_LEAD;
                    end
                    else if (!q_data.last && q_data.single_hit && is_punct)
                    begin
                        held_next = HELD_PUNCT;
                    end
                    else
                    begin
                        held_next = HELD_NONE;
                    end
                end
                default:
                begin
                    held_next = HELD_NONE;
                end
            endcase
        end
    end

    // Results produced by the item taken from the queue.
    always_comb
    begin
        res0    = own_res;
        res1    = own_res;
        res_cnt = 2'd0;
        unique case (held_reg) inside
            HELD_LEAD:
            begin
                res0.data     = held_byte_reg;
                res0.seg_end  = 1'b0;
                res0.line_end = 1'b0;
                res1.seg_end  = q_data.pair_hit || q_data.last;
                res_cnt       = 2'd2;
            end
            HELD_PUNCT:
            begin
                res0.data     = held_byte_reg;
                res0.seg_end  = !is_digit;
                res0.line_end = 1'b0;
                res_cnt       = own_emit ? 2'd2 : 2'd1;
            end
            HELD_NONE:
            begin
                res_cnt = own_emit ? 2'd1 : 2'd0;
            end
            default:
            begin
                res_cnt = own_emit ? 2'd1 : 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= HELD_NONE;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_byte_reg <= held_byte_next;
    end

    assign out_count_next = out_count_reg
                            + (q_pop ? OUT_CNT_W'(res_cnt) : OUT_CNT_W'(0))
                            - OUT_CNT_W'(drain);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                out_wr_ptr_reg <= out_wr_ptr_reg + OUT_PTR_W'(res_cnt);
            end
            if (drain)
            begin
                out_rd_ptr_reg <= out_rd_ptr_reg + OUT_PTR_W'(1);
            end
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && (res_cnt != 2'd0))
        begin
            out_buf_reg[out_wr_ptr_reg] <= res0;
        end
        if (q_pop && (res_cnt == 2'd2))
        begin
            out_buf_reg[out_wr_ptr_reg + OUT_PTR_W'(1)] <= res1;
        end
    end

    assign m_axis_tvalid   = (out_count_reg != '0);
    assign m_axis_tdata    = out_buf_reg[out_rd_ptr_reg].data;
    assign m_axis_tuser[0] = out_buf_reg[out_rd_ptr_reg].seg_end;
    assign m_axis_tlast    = out_buf_reg[out_rd_ptr_reg].line_end;

    `ASSERT_ALWAYS(a_out_bound, out_count_reg <= OUT_CNT_W'(OUT_DEPTH), "Output buffer overrun")
    `ASSERT_IMPLY(a_pop_room, q_pop, out_count_reg <= OUT_CNT_W'(OUT_DEPTH - 2), "Pop without room for two results")
    `ASSERT_NEXT(a_lead_done, q_pop && (held_reg == HELD_LEAD), held_reg == HELD_NONE, "Lead byte still held after its second byte")

endmodule

`default_nettype wire

// ----- rtl/punctuation_sentence_splitter.sv -----
// A text byte that needs no lookahead is registered in the match stage and the queue, and
// the output buffer offers it on m_axis; a held lead, comma or period byte leaves together
// with the following byte. Throughput: one input transfer per cycle while m_axis_tready is
// high, set by the fully parallel table match and the two-result output buffer. A table
// write takes effect for the very next text byte. Reset clears entry_count, the held
// character and both queues; table contents stay undefined until written.
`default_nettype none

module punctuation_sentence_splitter
    import splt_pkg::*;
#(
    parameter int TABLE_DEPTH = 128,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // text_byte[7:0], entry_index[14:8], entry_first[22:15], entry_second[30:23],
    // entry_two_byte[31]
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    // kind[0]
    input  wire logic [0:0]           s_axis_tuser,
    input  wire logic                 s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]                m_axis_tdata,
    // segment_end[0]
    output logic [0:0]                m_axis_tuser,
    output logic                      m_axis_tlast,
    input  wire logic                 cfg_wr_en,
    input  wire logic [7:0]           cfg_wr_data
);

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ITEM_W = $bits(text_item_t);

    logic             q_push;
    text_item_t       q_push_data;
    logic             q_pop;
    logic [ITEM_W-1:0] q_pop_bits;
    text_item_t       q_pop_data;
    logic             q_empty;
    logic [CNT_W-1:0] q_count;

    splt_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_count       (q_count),
        .q_push        (q_push),
        .q_push_data   (q_push_data)
    );

    splt_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_bits),
        .empty     (q_empty),
        .count     (q_count)
    );

    assign q_pop_data = text_item_t'(q_pop_bits);

    splt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_data        (q_pop_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- bench/tb_punctuation_sentence_splitter.sv -----
// Self-checking bench for punctuation_sentence_splitter: loads the punctuation table,
// sweeps entry_count over several settings and checks every marked byte against a predictor.
// Depends on splt_pkg and the splitter RTL only.
`default_nettype none

module tb_punctuation_sentence_splitter;
    import splt_pkg::*;

    localparam int DEPTH = 128;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SEGMENT_TEXT = 155;

    typedef struct packed {
        logic       kind;
        logic [7:0] text;
        logic       last;
        logic [6:0] index;
        logic [7:0] first;
        logic [7:0] second;
        logic       two_byte;
    } feed_item_t;

    localparam int FEED_W  = $bits(feed_item_t);
    localparam int ENTRY_W = $bits(entry_t);

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [0:0]           s_axis_tuser = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_wr_en = 1'b0;
    logic [7:0]           cfg_wr_data = '0;

    feed_item_t  byte_feed_q[$];
    out_item_t   split_q[$];
    feed_item_t  cur_item = '0;
    bit          in_fire = 1'b0;
    int          send_idle = 22;
    int          recv_idle = 55;
    bit          hold_arm = 1'b0;
    bit          rx_hold = 1'b0;
    int          cycle_count = 0;
    int          error_count = 0;
    int          bytes_in = 0;
    int          bytes_out = 0;
    int          seg_ends = 0;
    int          queued_text = 0;

    entry_t      punct_tab[DEPTH];
    held_state_t held = HELD_NONE;
    logic [7:0]  held_byte = '0;
    logic        held_hit = 1'b0;
    int          entry_limit = 0;

    punctuation_sentence_splitter #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] punct_char(input int sel);
        case (sel)
            0:       return CHAR_COMMA;
            1:       return CHAR_PERIOD;
            2:       return 8'h21;
            3:       return 8'h3F;
            4:       return 8'h3B;
            default: return 8'h3A;
        endcase
    endfunction

    function automatic logic [15:0] pair_chars(input int sel);
        case (sel)
            0:       return 16'hA1A3;
            1:       return 16'hE380;
            2:       return 16'hA12E;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic entry_t random_entry();
        entry_t     e;
        logic [15:0] p;
        int          sel;
        sel = $urandom_range(99);
        e = entry_t'(ENTRY_W'($urandom));
        if (sel < 40)
        begin
            e.two_byte = 1'b0;
            e.first = punct_char($urandom_range(5));
        end
        else if (sel < 65)
        begin
            p = pair_chars($urandom_range(3));
            e.two_byte = 1'b1;
            e.first = p[15:8];
            e.second = p[7:0];
        end
        return e;
    endfunction

    function automatic int active_entries();
        return (entry_limit > DEPTH) ? DEPTH : entry_limit;
    endfunction

    function automatic logic single_hit(input logic [7:0] c);
        for (int k = 0; k < active_entries(); k++)
            if (!punct_tab[k].two_byte && punct_tab[k].first == c)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic pair_hit(input logic [7:0] a, input logic [7:0] b);
        for (int k = 0; k < active_entries(); k++)
            if (punct_tab[k].two_byte && punct_tab[k].first == a && punct_tab[k].second == b)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void add_marked_byte(input logic [7:0] b, input logic seg,
                                            input logic lend);
        out_item_t r;
        r.data = b;
        r.seg_end = seg;
        r.line_end = lend;
        split_q.push_back(r);
    endfunction

    // Mirrors the splitter: lead bytes and matched commas or periods wait for the next byte.
    task automatic split_byte(input feed_item_t it);
        logic hit;
        logic digit;
        if (it.kind == KIND_ENTRY)
        begin
            punct_tab[it.index] = '{two_byte: it.two_byte, second: it.second, first: it.first};
            return;
        end
        if (held == HELD_LEAD)
        begin
            hit = pair_hit(held_byte, it.text);
            add_marked_byte(held_byte, 1'b0, 1'b0);
            add_marked_byte(it.text, hit || it.last, it.last);
            held = HELD_NONE;
            held_byte = '0;
            held_hit = 1'b0;
            return;
        end
        if (held == HELD_PUNCT)
        begin
            digit = (it.text >= CHAR_ZERO) && (it.text <= CHAR_NINE);
            add_marked_byte(held_byte, held_hit && !digit, 1'b0);
        end
        held = HELD_NONE;
        held_byte = '0;
        held_hit = 1'b0;
        if (it.text[7])
        begin
            if (it.last)
                add_marked_byte(it.text, 1'b1, 1'b1);
            else
            begin
                held = HELD_LEAD;
                held_byte = it.text;
            end
        end
        else
        begin
            hit = single_hit(it.text);
            if (it.last)
                add_marked_byte(it.text, 1'b1, 1'b1);
            else if (hit && (it.text == CHAR_COMMA || it.text == CHAR_PERIOD))
            begin
                held = HELD_PUNCT;
                held_byte = it.text;
                held_hit = 1'b1;
            end
            else
                add_marked_byte(it.text, hit, 1'b0);
        end
    endtask

    task automatic queue_text(input logic [7:0] b, input logic last);
        feed_item_t it;
        it = feed_item_t'(FEED_W'({$urandom, $urandom}));
        it.kind = KIND_TEXT;
        it.text = b;
        it.last = last;
        byte_feed_q.push_back(it);
        queued_text++;
    endtask

    task automatic queue_entry(input int idx, input entry_t e);
        feed_item_t it;
        it = feed_item_t'(FEED_W'({$urandom, $urandom}));
        it.kind = KIND_ENTRY;
        it.index = 7'(idx);
        it.first = e.first;
        it.second = e.second;
        it.two_byte = e.two_byte;
        byte_feed_q.push_back(it);
    endtask

    task automatic queue_random_line();
        int          len;
        int          k;
        int          sel;
        logic [7:0]  b;
        logic [15:0] p;
        len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24);
        k = 0;
        while (k < len)
        begin
            if ($urandom_range(99) < 4)
                queue_entry($urandom_range(DEPTH - 1), random_entry());
            sel = $urandom_range(99);
            if (sel < 30)
                b = punct_char($urandom_range(5));
            else if (sel < 45)
                b = CHAR_ZERO + 8'($urandom_range(9));
            else if (sel < 57 && k < len - 1)
            begin
                p = pair_chars($urandom_range(3));
                queue_text(p[15:8], 1'b0);
                k++;
                b = p[7:0];
            end
            else if (sel < 67)
                b = 8'($urandom_range(128, 255));
            else if (sel < 82)
                b = 8'($urandom_range(8'h61, 8'h7A));
            else
                b = 8'($urandom_range(255));
            queue_text(b, k == len - 1);
            k++;
        end
    endtask

    task automatic wait_idle();
        while (byte_feed_q.size() != 0 || s_axis_tvalid || split_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_entry_count(input int value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= 8'(value);
        entry_limit = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int count_for(input int seg);
        case (seg)
            0:       return 128;
            1:       return 0;
            2:       return 1;
            3:       return 5;
            4:       return 255;
            5:       return 40;
            6:       return 129;
            7:       return 127;
            default: return 128;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("Mismatch in %s at cycle %0d: got %0h, expected %0h",
                 what, cycle_count, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        in_fire = rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire)
        begin
            split_byte(cur_item);
            bytes_in++;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_fire)
        begin
            if (byte_feed_q.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                cur_item = byte_feed_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {cur_item.two_byte, cur_item.second, cur_item.first,
                                 cur_item.index, cur_item.text};
                s_axis_tuser <= cur_item.kind;
                s_axis_tlast <= cur_item.last;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle);
    end

    // The long receiver stall that backs the block up into its input.
    always
    begin
        @(posedge hold_arm);
        rx_hold = 1'b1;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            bytes_out++;
            if (m_axis_tuser[0])
                seg_ends++;
            if (split_q.size() == 0)
                report_mismatch("unexpected transfer", int'(m_axis_tdata), 0);
            else
            begin
                want = split_q.pop_front();
                if (m_axis_tdata !== want.data)
                    report_mismatch("out_byte", int'(m_axis_tdata), int'(want.data));
                if (m_axis_tuser[0] !== want.seg_end)
                    report_mismatch("segment_end", int'(m_axis_tuser[0]),
                                    int'(want.seg_end));
                if (m_axis_tlast !== want.line_end)
                    report_mismatch("line_end", int'(m_axis_tlast), int'(want.line_end));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        entry_t e;
        for (int k = 0; k < DEPTH; k++)
            punct_tab[k] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every slot is written before any count makes it visible.
        for (int k = 0; k < DEPTH; k++)
        begin
            e = random_entry();
            case (k)
                0: e = '{two_byte: 1'b0, second: 8'h00, first: CHAR_COMMA};
                1: e = '{two_byte: 1'b0, second: 8'hFF, first: CHAR_PERIOD};
                2: e = '{two_byte: 1'b0, second: 8'h00, first: 8'h21};
                3: e = '{two_byte: 1'b1, second: 8'hA3, first: 8'hA1};
                4: e = '{two_byte: 1'b1, second: 8'h80, first: 8'hE3};
                default: ;
            endcase
            queue_entry(k, e);
        end
        wait_idle();
        set_entry_count(128);

        // Lookahead on comma and period, code extremes, pairs, and a write while a lead waits.
        queue_text(CHAR_COMMA, 1'b0);
        queue_text(CHAR_ZERO, 1'b0);
        queue_text(CHAR_PERIOD, 1'b0);
        queue_text(CHAR_NINE, 1'b0);
        queue_text(CHAR_PERIOD, 1'b0);
        queue_text(8'h2F, 1'b0);
        queue_text(CHAR_COMMA, 1'b0);
        queue_text(8'h3A, 1'b0);
        queue_text(8'h21, 1'b0);
        queue_text(8'h00, 1'b0);
        queue_text(8'h7F, 1'b0);
        queue_text(8'hA1, 1'b0);
        queue_text(8'hA3, 1'b0);
        queue_text(8'hA1, 1'b0);
        queue_text(8'h41, 1'b0);
        queue_text(8'h80, 1'b0);
        queue_text(8'hFF, 1'b0);
        queue_text(8'hE3, 1'b0);
        queue_entry(4, '{two_byte: 1'b1, second: 8'h80, first: 8'hE3});
        queue_text(8'h80, 1'b0);
        queue_text(CHAR_COMMA, 1'b1);
        queue_text(8'hFF, 1'b1);
        queue_text(CHAR_PERIOD, 1'b1);
        wait_idle();

        for (int seg = 0; seg < 9; seg++)
        begin
            if (seg < 3)
            begin
                send_idle = 22;
                recv_idle = 55;
            end
            else if (seg < 6)
            begin
                send_idle = 55;
                recv_idle = 22;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            set_entry_count(count_for(seg));
            queued_text = 0;
            while (queued_text < SEGMENT_TEXT)
                queue_random_line();
            if (seg == 7)
            begin
                @(posedge clk);
                hold_arm = 1'b1;
            end
            wait_idle();
        end

        repeat (20) @(posedge clk);
        $display("Covered %0d input transfers and %0d output transfers, %0d ending a segment,",
                 bytes_in, bytes_out, seg_ends);
        $display("over nine entry_count settings from 0 to 255 and three stall patterns.");
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
